/* design/timed_pwm_speed_controller_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the timed PWM speed controller
// Clocked property checks on aclk, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef TIMED_PWM_SPEED_CONTROLLER_TOP_ASSERT_SVH
`define TIMED_PWM_SPEED_CONTROLLER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define TPSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);
// Check a property on every clock edge, reset included
`define TPSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define TPSC_ASSERT(lbl, prop, msg)
`define TPSC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/tpsc_pkg.sv */
// ---------------------------------------------------------------------------
// tpsc_pkg
// Types, widths and fixed-point constants shared by the speed controller.
// ---------------------------------------------------------------------------
package tpsc_pkg;

    // Field widths
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned SPEED_W = 10;
    localparam int unsigned IN_SPD_W = 16;
    localparam int unsigned DUR_W   = 16;
    localparam int unsigned TOP_W   = 16;
    localparam int unsigned CMP_W   = 17;
    localparam int unsigned REM_W   = 16;
    localparam int unsigned MS_W    = 23;

    // Scaling constants
    localparam int unsigned SPEED_FULL_SCALE = 1000;
    localparam int unsigned TICKS_PER_UNIT   = 100;
    localparam logic [TOP_W-1:0] TOP_RESET   = 16'd3599;
    localparam longint unsigned MS_MAX = (64'd1 << MS_W) - 64'd1;

    // Compare value: speed * (top + 1) / SPEED_FULL_SCALE via reciprocal
    localparam int unsigned PROD_W =
        $clog2(longint'(SPEED_FULL_SCALE) * (64'd1 << TOP_W) + 64'd1);
    localparam int unsigned DIV1_SH = PROD_W + $clog2(SPEED_FULL_SCALE);
    localparam longint unsigned RECIP1 =
        ((64'd1 << DIV1_SH) + SPEED_FULL_SCALE - 1) / SPEED_FULL_SCALE;
    localparam int unsigned RECIP1_W = $clog2(RECIP1 + 64'd1);

    // Remaining time: ceil(ms / TICKS_PER_UNIT) via reciprocal
    localparam int unsigned RNUM_W  = $clog2(MS_MAX + TICKS_PER_UNIT);
    localparam int unsigned DIV2_SH = RNUM_W + $clog2(TICKS_PER_UNIT);
    localparam longint unsigned RECIP2 =
        ((64'd1 << DIV2_SH) + TICKS_PER_UNIT - 1) / TICKS_PER_UNIT;
    localparam int unsigned RECIP2_W = $clog2(RECIP2 + 64'd1);
    localparam int unsigned Q2_W     = RNUM_W + RECIP2_W - DIV2_SH;

    // Request kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_SET_SPEED   = 2'd0,
        MODE_START_TIMED = 2'd1,
        MODE_STOP        = 2'd2,
        MODE_TICK        = 2'd3
    } mode_t;

    // Controller state after one request, plus per-request flags
    typedef struct packed {
        logic               accepted;
        logic               expired;
        logic [SPEED_W-1:0] speed;
        logic               run;
        logic [MS_W-1:0]    rem_ms;
    } snap_t;

    // Middle pipeline stage
    typedef struct packed {
        logic               accepted;
        logic               expired;
        logic [SPEED_W-1:0] speed;
        logic               run;
        logic [PROD_W-1:0]  prod;
        logic [RNUM_W-1:0]  rnum;
    } mid_t;

endpackage

/* design/tpsc_cmd.sv */
// ---------------------------------------------------------------------------
// tpsc_cmd
// Request decoder and controller state: speed, run flag, millisecond timer.
// ---------------------------------------------------------------------------
module tpsc_cmd
    import tpsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_accept,
    input  logic [MODE_W-1:0]   req_mode,
    input  logic [IN_SPD_W-1:0] req_speed,
    input  logic [DUR_W-1:0]    req_duration,
    output snap_t               snap
);

    `include "timed_pwm_speed_controller_top_assert.svh"

    logic [SPEED_W-1:0] speed_reg,  speed_next;
    logic               run_reg,    run_next;
    logic [MS_W-1:0]    rem_ms_reg, rem_ms_next;

    logic [SPEED_W-1:0] clamped;
    logic [31:0]        ms_full;
    logic [MS_W-1:0]    ms_sat;
    logic [MS_W-1:0]    rem_dec;
    logic               accepted;
    logic               expired;

    // Clamp requested speed, scale the run length and decrement the timer
    always_comb begin
        clamped = (req_speed > IN_SPD_W'(SPEED_FULL_SCALE))
                ? SPEED_W'(SPEED_FULL_SCALE) : req_speed[SPEED_W-1:0];
        ms_full = 32'(req_duration) * 32'(TICKS_PER_UNIT);
        ms_sat  = (ms_full > 32'(MS_MAX)) ? MS_W'(MS_MAX) : ms_full[MS_W-1:0];
        rem_dec = (rem_ms_reg != '0) ? rem_ms_reg - 1'b1 : '0;
    end

    // Next state per request kind
    always_comb begin
        speed_next  = speed_reg;
        run_next    = run_reg;
        rem_ms_next = rem_ms_reg;
        accepted    = 1'b1;
        expired     = 1'b0;
        unique case (mode_t'(req_mode))
            MODE_SET_SPEED: begin
                if (req_speed == '0) begin
                    speed_next  = '0;
                    run_next    = 1'b0;
                    rem_ms_next = '0;
                end else begin
                    speed_next = clamped;
                end
            end
            MODE_START_TIMED: begin
                if (req_speed == '0) begin
                    speed_next  = '0;
                    run_next    = 1'b0;
                    rem_ms_next = '0;
                end else if (req_duration == '0) begin
                    accepted = 1'b0;
                end else begin
                    speed_next  = clamped;
                    run_next    = 1'b1;
                    rem_ms_next = ms_sat;
                end
            end
            MODE_STOP: begin
                speed_next  = '0;
                run_next    = 1'b0;
                rem_ms_next = '0;
            end
            MODE_TICK: begin
                if (run_reg) begin
                    if (rem_dec == '0) begin
                        speed_next  = '0;
                        run_next    = 1'b0;
                        rem_ms_next = '0;
                        expired     = 1'b1;
                    end else begin
                        rem_ms_next = rem_dec;
                    end
                end
            end
            default: ;
        endcase
    end

    // State registers, updated only on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg  <= '0;
            run_reg    <= 1'b0;
            rem_ms_reg <= '0;
        end else if (req_accept) begin
            speed_reg  <= speed_next;
            run_reg    <= run_next;
            rem_ms_reg <= rem_ms_next;
        end
    end

    assign snap = '{accepted: accepted, expired: expired, speed: speed_next,
                    run: run_next, rem_ms: rem_ms_next};

    // A running timer always has time left and a nonzero speed
    `TPSC_ASSERT(a_run_consistent, run_reg |-> (rem_ms_reg != '0 && speed_reg != '0),
                 "run flag set with no time left or zero speed")
    // Idle timer holds no time
    `TPSC_ASSERT(a_idle_no_time, !run_reg |-> rem_ms_reg == '0,
                 "time left while no run is active")
    // Applied speed never exceeds full scale
    `TPSC_ASSERT(a_speed_clamped, speed_reg <= SPEED_W'(SPEED_FULL_SCALE),
                 "applied speed above full scale")
    // A stop request halts everything
    `TPSC_ASSERT(a_stop_halts,
                 (req_accept && req_mode == MODE_STOP) |=> (speed_reg == '0 && !run_reg),
                 "stop request did not halt the motor")

endmodule

/* design/tpsc_scale.sv */
// ---------------------------------------------------------------------------
// tpsc_scale
// Result pipeline: compare value and remaining time units, with output reg.
// ---------------------------------------------------------------------------
module tpsc_scale
    import tpsc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  snap_t            in_snap,
    input  logic [TOP_W-1:0] counter_top,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_accepted,
    output logic             out_drive_enable,
    output logic [CMP_W-1:0] out_compare_value,
    output logic [SPEED_W-1:0] out_applied_speed,
    output logic             out_timed_running,
    output logic [REM_W-1:0] out_remaining_100ms,
    output logic             out_expired
);

    logic v1_reg, v2_reg, v3_reg;
    logic ld1, ld2, ld3;

    snap_t s1_reg;
    mid_t  s2_reg;
    mid_t  s2_next;

    logic [PROD_W+RECIP1_W-1:0] mult1;
    logic [RNUM_W+RECIP2_W-1:0] mult2;
    logic [Q2_W-1:0]            quot2;
    logic [TOP_W+SPEED_W:0]     prod_full;

    logic               acc_reg, en_reg, run_reg, exp_reg;
    logic [CMP_W-1:0]   cmp_reg;
    logic [SPEED_W-1:0] spd_reg;
    logic [REM_W-1:0]   rem_reg;

    // Stall control: a stage loads when it is empty or its successor moves
    assign ld3      = !v3_reg || out_ready;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
        end
    end

    // Stage 1: snapshot of the state after the request
    always_ff @(posedge aclk) begin
        if (ld1 && in_valid) s1_reg <= in_snap;
    end

    // Stage 2: raw product and rounded-up numerator
    always_comb begin
        prod_full        = (TOP_W + SPEED_W + 1)'(s1_reg.speed)
                         * ((TOP_W + SPEED_W + 1)'(counter_top) + 1'b1);
        s2_next.accepted = s1_reg.accepted;
        s2_next.expired  = s1_reg.expired;
        s2_next.speed    = s1_reg.speed;
        s2_next.run      = s1_reg.run;
        s2_next.prod     = prod_full[PROD_W-1:0];
        s2_next.rnum     = (s1_reg.run && s1_reg.rem_ms != '0)
                         ? RNUM_W'(s1_reg.rem_ms) + RNUM_W'(TICKS_PER_UNIT - 1)
                         : '0;
    end

    always_ff @(posedge aclk) begin
        if (ld2 && v1_reg) s2_reg <= s2_next;
    end

    // Stage 3: reciprocal multiplies for both divisions, output register
    always_comb begin
        mult1 = (PROD_W + RECIP1_W)'(s2_reg.prod) * (PROD_W + RECIP1_W)'(RECIP1);
        mult2 = (RNUM_W + RECIP2_W)'(s2_reg.rnum) * (RNUM_W + RECIP2_W)'(RECIP2);
        quot2 = mult2[DIV2_SH +: Q2_W];
    end

    always_ff @(posedge aclk) begin
        if (ld3 && v2_reg) begin
            acc_reg <= s2_reg.accepted;
            exp_reg <= s2_reg.expired;
            spd_reg <= s2_reg.speed;
            en_reg  <= (s2_reg.speed != '0);
            run_reg <= s2_reg.run;
            cmp_reg <= mult1[DIV1_SH +: CMP_W];
            rem_reg <= (quot2[Q2_W-1:REM_W] != '0) ? '1 : quot2[REM_W-1:0];
        end
    end

    assign out_valid           = v3_reg;
    assign out_accepted        = acc_reg;
    assign out_drive_enable    = en_reg;
    assign out_compare_value   = cmp_reg;
    assign out_applied_speed   = spd_reg;
    assign out_timed_running   = run_reg;
    assign out_remaining_100ms = rem_reg;
    assign out_expired         = exp_reg;

endmodule

/* design/timed_pwm_speed_controller_top.sv */
// ---------------------------------------------------------------------------
// timed_pwm_speed_controller_top
// Motor PWM compare and enable from speed requests, with a timed run.
// ---------------------------------------------------------------------------
// Input stream (s_): one request per item; s_tuser carries the request kind
// (set speed, start timed run, stop, one-millisecond tick), s_tdata carries
// the speed in per-mille and the run length in 100 ms units.
// Result stream (m_): exactly one result per request, in request order, with
// the compare count, enable, applied speed, run flag, remaining time in
// 100 ms units (rounded up) and the expiry flag.
// Config channel (cfg_): writes counter_top, the PWM timer top count; write
// it only while no request is in flight. cfg_ready is always high.
// Throughput: one request per cycle while m_tready does not stall it.
// Controller state updates at acceptance, so the next request may follow
// in the very next cycle. From acceptance to m_tvalid a request passes the
// snapshot, product and reciprocal-multiply output registers.
// Reset: speed 0, run stopped, no time left, counter_top 3599, no results.
// When the receiver stalls, results hold and the three stages fill; s_tready
// drops only once all stages are occupied.
// ---------------------------------------------------------------------------
module timed_pwm_speed_controller_top
    import tpsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] speed, [31:16] run length
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [0] accepted, [1] drive_enable,
                                   // [18:2] compare_value, [28:19] applied_speed,
                                   // [29] timed_running, [45:30] remaining_100ms,
                                   // [46] expired, [47] zero
    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // counter_top
);

    logic [TOP_W-1:0]   counter_top_reg;
    logic               req_accept;
    snap_t              snap;

    logic               o_accepted;
    logic               o_drive_enable;
    logic [CMP_W-1:0]   o_compare_value;
    logic [SPEED_W-1:0] o_applied_speed;
    logic               o_timed_running;
    logic [REM_W-1:0]   o_remaining_100ms;
    logic               o_expired;

    // Top count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_top_reg <= TOP_RESET;
        end else if (cfg_valid) begin
            counter_top_reg <= cfg_data;
        end
    end

    assign req_accept = s_tvalid && s_tready;

    // Request decode and controller state
    tpsc_cmd u_cmd (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_accept   (req_accept),
        .req_mode     (s_tuser),
        .req_speed    (s_tdata[15:0]),
        .req_duration (s_tdata[31:16]),
        .snap         (snap)
    );

    // Result arithmetic and output register
    tpsc_scale u_scale (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (s_tvalid),
        .in_ready            (s_tready),
        .in_snap             (snap),
        .counter_top         (counter_top_reg),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .out_accepted        (o_accepted),
        .out_drive_enable    (o_drive_enable),
        .out_compare_value   (o_compare_value),
        .out_applied_speed   (o_applied_speed),
        .out_timed_running   (o_timed_running),
        .out_remaining_100ms (o_remaining_100ms),
        .out_expired         (o_expired)
    );

    // Result packing
    assign m_tdata = {1'b0, o_expired, o_remaining_100ms, o_timed_running,
                      o_applied_speed, o_compare_value, o_drive_enable, o_accepted};

endmodule
